### rtl/core/xs128p_pkg.sv
// ----------------------------------------------------------------------------
// xs128p_pkg
// Shared widths, codes and constants of the xorshift128+ generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xs128p_pkg;

    // field and register widths
    localparam int WORD_W    = 64;
    localparam int LIMIT_W   = 63;
    localparam int COUNT_W   = 6;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;

    // request codes, the unused code acts as a raw draw
    localparam logic [REQ_W-1:0] REQ_RAW   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MASK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BOUND = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SECOND = 2'd2;

    // murmur3 finalizer constants
    localparam logic [WORD_W-1:0] MIX_MUL_ONE = 64'hff51_afd7_ed55_8ccd;
    localparam logic [WORD_W-1:0] MIX_MUL_TWO = 64'hc4ce_b9fe_1a85_ec53;
    localparam int                MIX_SHIFT   = 33;
    localparam int                MIX_ROUNDS  = 3;
    localparam logic [WORD_W-1:0] SIGN_BIT    = 64'h8000_0000_0000_0000;

    // xorshift128+ shift amounts
    localparam int XS_SHIFT_A = 23;
    localparam int XS_SHIFT_B = 17;
    localparam int XS_SHIFT_C = 26;

    // one dividend bit per divider step
    localparam int DIV_STEPS = LIMIT_W;

    // sequencer states
    typedef enum logic [2:0] {
        ST_SEED,
        ST_MIX_XOR,
        ST_MIX_MUL,
        ST_IDLE,
        ST_DRAW,
        ST_DIV,
        ST_CHECK
    } t_state;

endpackage

`default_nettype wire

### rtl/core/xs128p_req_if.sv
// ----------------------------------------------------------------------------
// xs128p_req_if
// Request channel: one word asks for one draw.
// ----------------------------------------------------------------------------
`default_nettype none

interface xs128p_req_if import xs128p_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [LIMIT_W-1:0] bound_limit;
    logic [COUNT_W-1:0] bit_count;

    modport source (output valid, output req_type, output bound_limit, output bit_count,
                    input ready);
    modport sink   (input valid, input req_type, input bound_limit, input bit_count,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/xs128p_rsp_if.sv
// ----------------------------------------------------------------------------
// xs128p_rsp_if
// Result channel: one word carries one drawn value.
// ----------------------------------------------------------------------------
`default_nettype none

interface xs128p_rsp_if import xs128p_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] draw_value;

    modport source (output valid, output draw_value, input ready);
    modport sink   (input valid, input draw_value, output ready);
endinterface

`default_nettype wire

### rtl/core/xorshift128plus_generator_top.sv
// ----------------------------------------------------------------------------
// xorshift128plus_generator_top
// xorshift128+ generator with hashed or direct seeding and raw, masked
// or bounded draws, built around one small sequencer.
// ----------------------------------------------------------------------------
// usage
//   i_req  : request word (type, bound, bit count), taken when valid & ready
//   o_rsp  : one result word per request, held until the receiver takes it
//   i_cfg_*: register write port, any write to a known register reseeds
// draws and seeding
//   raw and masked draws: the request is registered, the draw state writes the
//   result to the output register, and the next request is taken after that
//   bounded draws: each attempt is 1 draw, 63 steps of the radix-2 remainder
//   unit and 1 acceptance check, redrawn on rejection (a zero bound returns the
//   draw shifted right by one); the next request is taken once a check accepts
//   hashed seeding: 2 x (3 xor + 2 x 3 multiply) steps on one 32x32 multiplier
// reset
//   control and seed registers clear to zero, the hashed seed sequence runs; i_req is
//   not ready until it completes
// stall
//   a result waits in the output register; the next request is accepted,
//   and its draw is held until the output register frees up
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift128plus_generator_top import xs128p_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    xs128p_req_if.sink           i_req,
    xs128p_rsp_if.source         o_rsp
);

    // control registers
    t_state               r_state, n_state;
    logic                 r_seed_mode;
    logic [WORD_W-1:0]    r_seed_first;
    logic [WORD_W-1:0]    r_seed_second;
    logic                 r_out_valid, n_out_valid;

    // payload registers
    logic [WORD_W-1:0]    r_gen_a, n_gen_a;
    logic [WORD_W-1:0]    r_gen_b, n_gen_b;
    logic [WORD_W-1:0]    r_mix, n_mix;
    logic [WORD_W-1:0]    r_acc, n_acc;
    logic [1:0]           r_round, n_round;
    logic [1:0]           r_phase, n_phase;
    logic                 r_word, n_word;
    logic [REQ_W-1:0]     r_req_type, n_req_type;
    logic [LIMIT_W-1:0]   r_limit, n_limit;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [WORD_W-1:0]    r_room, n_room;
    logic [LIMIT_W-1:0]   r_bits, n_bits;
    logic [LIMIT_W-1:0]   r_dvd, n_dvd;
    logic [LIMIT_W-1:0]   r_rem, n_rem;
    logic [COUNT_W-1:0]   r_div_cnt, n_div_cnt;
    logic [WORD_W-1:0]    r_out_data, n_out_data;

    // shared datapath signals
    logic                 cfg_hit;
    logic                 in_accept;
    logic                 out_free;
    logic [WORD_W-1:0]    mix_xor;
    logic [WORD_W-1:0]    mul_const;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [WORD_W-1:0]    mul_p;
    logic [WORD_W-1:0]    mul_sum;
    logic [WORD_W-1:0]    xs_x;
    logic [WORD_W-1:0]    xs_next_b;
    logic [WORD_W-1:0]    xs_sum;
    logic [WORD_W-1:0]    draw_mask;
    logic [WORD_W-1:0]    div_trial;
    logic                 div_fits;
    logic [WORD_W-1:0]    chk_diff;
    logic                 bound_ok;

    assign cfg_hit   = i_cfg_we && (i_cfg_idx == CFG_SEED_MODE ||
                                    i_cfg_idx == CFG_SEED_FIRST ||
                                    i_cfg_idx == CFG_SEED_SECOND);
    assign in_accept = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.draw_value = r_out_data;

    // finalizer xor-shift step
    assign mix_xor = r_mix ^ (r_mix >> MIX_SHIFT);

    // shared 32x32 multiplier, low 64 bits of the 64x64 product over 3 phases
    assign mul_const = (r_round == 2'd0) ? MIX_MUL_ONE : MIX_MUL_TWO;
    assign mul_a     = (r_phase == 2'd1) ? r_mix[63:32] : r_mix[31:0];
    assign mul_b     = (r_phase == 2'd2) ? mul_const[63:32] : mul_const[31:0];
    assign mul_p     = WORD_W'(mul_a) * WORD_W'(mul_b);
    assign mul_sum   = r_acc + {mul_p[31:0], 32'd0};

    // xorshift128+ step
    assign xs_x      = r_gen_a ^ (r_gen_a << XS_SHIFT_A);
    assign xs_next_b = xs_x ^ r_gen_b ^ (xs_x >> XS_SHIFT_B) ^ (r_gen_b >> XS_SHIFT_C);
    assign xs_sum    = xs_next_b + r_gen_b;
    assign draw_mask = (WORD_W'(1) << r_count) - WORD_W'(1);

    // restoring remainder step
    assign div_trial = {r_rem, r_dvd[LIMIT_W-1]};
    assign div_fits  = (div_trial >= {1'b0, r_limit});

    // rejection check: bits - value must not exceed 2^63 - n
    assign chk_diff  = {1'b0, r_bits} - {1'b0, r_rem};
    assign bound_ok  = (chk_diff <= r_room);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SEED: begin
                n_state = r_seed_mode ? ST_IDLE : ST_MIX_XOR;
            end
            ST_MIX_XOR: begin
                if (r_round == 2'(MIX_ROUNDS - 1)) begin
                    n_state = r_word ? ST_IDLE : ST_MIX_XOR;
                end else begin
                    n_state = ST_MIX_MUL;
                end
            end
            ST_MIX_MUL: begin
                if (r_phase == 2'd2) begin
                    n_state = ST_MIX_XOR;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (out_free) begin
                    if (r_req_type == REQ_BOUND && r_limit != '0) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (r_div_cnt == COUNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!bound_ok) begin
                    n_state = ST_DRAW;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_SEED;
            end
        endcase
        // a register write restarts seeding
        if (cfg_hit) begin
            n_state = ST_SEED;
        end
    end

    // datapath and outputs
    always_comb begin
        n_gen_a    = r_gen_a;
        n_gen_b    = r_gen_b;
        n_mix      = r_mix;
        n_acc      = r_acc;
        n_round    = r_round;
        n_phase    = r_phase;
        n_word     = r_word;
        n_req_type = r_req_type;
        n_limit    = r_limit;
        n_count    = r_count;
        n_room     = r_room;
        n_bits     = r_bits;
        n_dvd      = r_dvd;
        n_rem      = r_rem;
        n_div_cnt  = r_div_cnt;
        n_out_data = r_out_data;
        n_out_valid = r_out_valid && !o_rsp.ready;
        unique case (r_state)
            ST_SEED: begin
                if (r_seed_mode) begin
                    n_gen_a = r_seed_first;
                    n_gen_b = r_seed_second;
                end else begin
                    n_mix   = (r_seed_first == '0) ? SIGN_BIT : r_seed_first;
                    n_round = 2'd0;
                    n_phase = 2'd0;
                    n_word  = 1'b0;
                end
            end
            ST_MIX_XOR: begin
                n_mix = mix_xor;
                if (r_round == 2'(MIX_ROUNDS - 1)) begin
                    n_round = 2'd0;
                    if (r_word) begin
                        n_gen_b = mix_xor;
                    end else begin
                        n_gen_a = mix_xor;
                        n_word  = 1'b1;
                    end
                end
            end
            ST_MIX_MUL: begin
                case (r_phase)
                    2'd0: begin
                        n_acc   = mul_p;
                        n_phase = 2'd1;
                    end
                    2'd1: begin
                        n_acc   = mul_sum;
                        n_phase = 2'd2;
                    end
                    default: begin
                        n_mix   = mul_sum;
                        n_phase = 2'd0;
                        n_round = r_round + 2'd1;
                    end
                endcase
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_req_type = i_req.req_type;
                    n_limit    = i_req.bound_limit;
                    n_count    = i_req.bit_count;
                    n_room     = SIGN_BIT - {1'b0, i_req.bound_limit};
                end
            end
            ST_DRAW: begin
                if (out_free) begin
                    n_gen_a = r_gen_b;
                    n_gen_b = xs_next_b;
                    case (r_req_type)
                        REQ_MASK: begin
                            n_out_data  = xs_sum & draw_mask;
                            n_out_valid = 1'b1;
                        end
                        REQ_BOUND: begin
                            if (r_limit == '0) begin
                                n_out_data  = {1'b0, xs_sum[WORD_W-1:1]};
                                n_out_valid = 1'b1;
                            end else begin
                                n_bits    = xs_sum[WORD_W-1:1];
                                n_dvd     = xs_sum[WORD_W-1:1];
                                n_rem     = '0;
                                n_div_cnt = '0;
                            end
                        end
                        default: begin
                            n_out_data  = xs_sum;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_rem     = div_fits ? LIMIT_W'(div_trial - {1'b0, r_limit})
                                     : div_trial[LIMIT_W-1:0];
                n_dvd     = {r_dvd[LIMIT_W-2:0], 1'b0};
                n_div_cnt = r_div_cnt + COUNT_W'(1);
            end
            ST_CHECK: begin
                if (bound_ok && out_free) begin
                    n_out_data  = {1'b0, r_rem};
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !o_rsp.ready;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SEED;
            r_out_valid   <= 1'b0;
            r_seed_mode   <= 1'b0;
            r_seed_first  <= '0;
            r_seed_second <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SEED_MODE:   r_seed_mode   <= i_cfg_data[0];
                    CFG_SEED_FIRST:  r_seed_first  <= i_cfg_data;
                    CFG_SEED_SECOND: r_seed_second <= i_cfg_data;
                    default:         r_seed_mode   <= r_seed_mode;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_gen_a    <= n_gen_a;
        r_gen_b    <= n_gen_b;
        r_mix      <= n_mix;
        r_acc      <= n_acc;
        r_round    <= n_round;
        r_phase    <= n_phase;
        r_word     <= n_word;
        r_req_type <= n_req_type;
        r_limit    <= n_limit;
        r_count    <= n_count;
        r_room     <= n_room;
        r_bits     <= n_bits;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_div_cnt  <= n_div_cnt;
        r_out_data <= n_out_data;
    end

    // a write to a known register always restarts seeding
    a_cfg_reseed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> r_state == ST_SEED)
        else $error("register write did not restart seeding");

    // the remainder handed to the check is below the bound
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CHECK |-> r_rem < r_limit)
        else $error("remainder not below bound");

    // a result word appears only from a draw or an accepted bounded check
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DRAW || $past(r_state) == ST_CHECK))
        else $error("result word from unexpected state");

endmodule

`default_nettype wire
